/* rtl/core/hpap_pkg.sv */
// Package for the hot position access profiler.
// Holds field widths, action and register codes, item and control structs,
// and the small helper functions used by the datapath.
package hpap_pkg;

    // Default depth of the position table.
    localparam int TRACKED_ENTRIES_DEF = 4;

    // Field and counter widths.
    localparam int POS_W     = 31;
    localparam int CNT_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int ACT_W     = 2;
    localparam int NUM_CFG   = 6;
    localparam int CFG_IDX_W = 3;

    // Counters stop at all ones.
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_COLD = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EXIT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_COLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_EXIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERAL_EXIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MISSING_COLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COW_COLD     = 3'd5;

    // One access event.
    typedef struct packed {
        logic             position_valid;
        logic [POS_W-1:0] position;
        logic             small_static;
        logic             array_empty;
        logic             key_known_missing;
        logic             no_copy_on_write;
    } evt_t;

    // One profile decision.
    typedef struct packed {
        logic [ACT_W-1:0] offset_action;
        logic [POS_W-1:0] offset_position;
        logic             small_hint;
        logic [ACT_W-1:0] empty_action;
        logic [ACT_W-1:0] missing_action;
        logic [ACT_W-1:0] nocow_action;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 capture;
        logic                 update;
        logic                 scan_step;
        logic                 mul_en;
        logic [CFG_IDX_W-1:0] mul_sel;
        logic                 cmp_en;
        logic [CFG_IDX_W-1:0] cmp_sel;
        logic                 emit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
    } ctl_sts_t;

    // Saturating increment of a counter.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    // Exit wins over cold; neither gives no action.
    function automatic logic [ACT_W-1:0] pick_action(input logic exit_met,
                                                     input logic cold_met);
        if (exit_met)
        begin
            pick_action = ACT_EXIT;
        end
        else if (cold_met)
        begin
            pick_action = ACT_COLD;
        end
        else
        begin
            pick_action = ACT_NONE;
        end
    endfunction

endpackage

/* rtl/core/hot_position_access_profiler.sv */
// Hot position access profiler: one event item in, one decision item out.
// Each item runs through these steps before the next one is accepted: it is
// taken in, the table and counters are updated, a scan over every table
// entry builds the total and finds the hottest entry, the shared multiplier
// forms total times each of the six fractions for the share compares, and
// the result register is loaded. A waiting result does not block the next item
// from being accepted. Configuration writes are always ready and take effect
// at once; write them only while the block is idle. Depends on hpap_pkg,
// hpap_ctrl and hpap_dp.
module hot_position_access_profiler
#(
    parameter int TRACKED_ENTRIES = hpap_pkg::TRACKED_ENTRIES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hpap_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpap_pkg::FRAC_W-1:0]       cfg_data,
    input  logic                              evt_valid,
    output logic                              evt_stall,
    input  hpap_pkg::evt_t                    evt_data,
    output logic                              res_valid,
    input  logic                              res_stall,
    output hpap_pkg::res_t                    res_data
);

    hpap_pkg::ctl_cmd_t cmd;
    hpap_pkg::ctl_sts_t sts;
    logic               cfg_we;

    // Register writes are taken every cycle.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    hpap_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    hpap_dp
    #(
        .TRACKED_ENTRIES (TRACKED_ENTRIES)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .evt_data  (evt_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_data  (res_data)
    );

endmodule

/* rtl/core/hpap_ctrl.sv */
// Controller of the hot position access profiler.
// Sequences update, table scan, threshold evaluation and result hand-off.
// Depends on hpap_pkg for the command and status structs.
module hpap_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                evt_valid,
    output logic                evt_stall,
    output logic                res_valid,
    input  logic                res_stall,
    output hpap_pkg::ctl_cmd_t  cmd,
    input  hpap_pkg::ctl_sts_t  sts
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPDATE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_EVAL   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    // Evaluation runs one product per fraction plus one trailing compare step.
    localparam logic [hpap_pkg::CFG_IDX_W-1:0] EVAL_LAST =
        hpap_pkg::CFG_IDX_W'(hpap_pkg::NUM_CFG);

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    logic [hpap_pkg::CFG_IDX_W-1:0]   eval_reg;
    logic [hpap_pkg::CFG_IDX_W-1:0]   eval_next;
    logic                             res_valid_reg;
    logic                             res_valid_next;
    logic                             accept;
    logic                             res_free;
    logic                             in_eval;

    // Handshake decode.
    assign evt_stall = (state_reg != ST_IDLE);
    assign accept    = evt_valid && !evt_stall;
    assign res_free  = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign in_eval   = (state_reg == ST_EVAL);

    // Commands to the datapath.
    always_comb
    begin
        cmd           = '0;
        cmd.capture   = accept;
        cmd.update    = (state_reg == ST_UPDATE);
        cmd.scan_step = (state_reg == ST_SCAN);
        cmd.mul_en    = in_eval && (eval_reg != EVAL_LAST);
        cmd.mul_sel   = eval_reg;
        cmd.cmp_en    = in_eval && (eval_reg != '0);
        cmd.cmp_sel   = eval_reg - 1'b1;
        cmd.emit      = (state_reg == ST_EMIT) && res_free;
    end

    // Next state and evaluation step.
    always_comb
    begin
        state_next = state_reg;
        eval_next  = eval_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                eval_next = '0;
                if (sts.scan_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                eval_next = eval_reg + 1'b1;
                if (eval_reg == EVAL_LAST)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result stays offered until the receiver takes it.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            eval_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            eval_reg      <= eval_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

/* rtl/core/hpap_dp.sv */
// Datapath of the hot position access profiler.
// Holds the fractions, the position table, the flag counters, the scan,
// the shared multiplier and the result register. Depends on hpap_pkg.
module hpap_dp
#(
    parameter int TRACKED_ENTRIES = hpap_pkg::TRACKED_ENTRIES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  hpap_pkg::ctl_cmd_t                cmd,
    output hpap_pkg::ctl_sts_t                sts,
    input  hpap_pkg::evt_t                    evt_data,
    input  logic                              cfg_we,
    input  logic [hpap_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpap_pkg::FRAC_W-1:0]       cfg_data,
    output hpap_pkg::res_t                    res_data
);

    localparam int N      = TRACKED_ENTRIES;
    localparam int IDX_W  = (N > 1) ? $clog2(N) : 1;
    localparam int TOT_W  = hpap_pkg::CNT_W + $clog2(N + 1);
    localparam int PROD_W = TOT_W + hpap_pkg::FRAC_W;
    localparam int CNT_W  = hpap_pkg::CNT_W;
    localparam int POS_W  = hpap_pkg::POS_W;

    hpap_pkg::evt_t                 evt_reg;
    logic [hpap_pkg::FRAC_W-1:0]    frac_reg [hpap_pkg::NUM_CFG];

    logic [N-1:0]                   entry_valid_reg;
    logic [POS_W-1:0]               entry_pos_reg [N];
    logic [CNT_W-1:0]               entry_cnt_reg [N];

    logic [CNT_W-1:0]               untracked_reg;
    logic [CNT_W-1:0]               untracked_next;
    logic [CNT_W-1:0]               small_reg;
    logic [CNT_W-1:0]               empty_reg;
    logic [CNT_W-1:0]               missing_reg;
    logic [CNT_W-1:0]               nocow_reg;

    logic [IDX_W-1:0]               ptr_reg;
    logic [TOT_W-1:0]               total_reg;
    logic [CNT_W-1:0]               hot_cnt_reg;
    logic [POS_W-1:0]               hot_pos_reg;
    logic [PROD_W-1:0]              prod_reg;

    logic                           hot_cold_reg;
    logic                           hot_exit_reg;
    logic                           small_met_reg;
    logic                           empty_exit_reg;
    logic                           empty_cold_reg;
    logic                           missing_exit_reg;
    logic                           missing_cold_reg;
    logic                           nocow_exit_reg;
    logic                           nocow_cold_reg;

    hpap_pkg::res_t                 res_reg;
    hpap_pkg::res_t                 res_next;

    logic                           found;
    logic [IDX_W-1:0]               hit_idx;
    logic                           recorded;
    logic [CNT_W-1:0]               scan_cnt;
    logic                           scan_valid;
    logic [hpap_pkg::ACT_W-1:0]     hot_act;

    // Share test: count scaled by 2^16 against total times fraction.
    function automatic logic share_met(input logic [CNT_W-1:0] v,
                                       input logic [PROD_W-1:0] prod);
        share_met = PROD_W'({v, {hpap_pkg::FRAC_W{1'b0}}}) >= prod;
    endfunction

    // First entry that either holds this position or is still free.
    always_comb
    begin
        found   = 1'b0;
        hit_idx = '0;
        for (int k = 0; k < N; k++)
        begin
            if (!found && (!entry_valid_reg[k] ||
                           (entry_pos_reg[k] == evt_reg.position)))
            begin
                found   = 1'b1;
                hit_idx = IDX_W'(k);
            end
        end
    end

    assign recorded       = evt_reg.position_valid && found;
    assign untracked_next = recorded ? untracked_reg : hpap_pkg::sat_inc(untracked_reg);

    // Scan reads one table entry per cycle.
    assign scan_cnt     = entry_cnt_reg[ptr_reg];
    assign scan_valid   = entry_valid_reg[ptr_reg];
    assign sts.scan_last = (ptr_reg == IDX_W'(N - 1));

    // Configuration, valid bits, counters and scan pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hpap_pkg::NUM_CFG; i++)
            begin
                frac_reg[i] <= '0;
            end
            entry_valid_reg <= '0;
            untracked_reg   <= '0;
            small_reg       <= '0;
            empty_reg       <= '0;
            missing_reg     <= '0;
            nocow_reg       <= '0;
            ptr_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                for (int i = 0; i < hpap_pkg::NUM_CFG; i++)
                begin
                    if (cfg_index == hpap_pkg::CFG_IDX_W'(i))
                    begin
                        frac_reg[i] <= cfg_data;
                    end
                end
            end
            if (cmd.update)
            begin
                if (recorded)
                begin
                    entry_valid_reg[hit_idx] <= 1'b1;
                end
                untracked_reg <= untracked_next;
                if (evt_reg.small_static)
                begin
                    small_reg <= hpap_pkg::sat_inc(small_reg);
                end
                if (evt_reg.array_empty)
                begin
                    empty_reg <= hpap_pkg::sat_inc(empty_reg);
                end
                if (evt_reg.key_known_missing)
                begin
                    missing_reg <= hpap_pkg::sat_inc(missing_reg);
                end
                if (evt_reg.no_copy_on_write)
                begin
                    nocow_reg <= hpap_pkg::sat_inc(nocow_reg);
                end
                ptr_reg <= '0;
            end
            else if (cmd.scan_step && !sts.scan_last)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    // Table payload: count up a hit or fill the first free entry.
    always_ff @(posedge clk)
    begin
        if (cmd.update && recorded)
        begin
            for (int k = 0; k < N; k++)
            begin
                if (hit_idx == IDX_W'(k))
                begin
                    if (entry_valid_reg[k])
                    begin
                        entry_cnt_reg[k] <= hpap_pkg::sat_inc(entry_cnt_reg[k]);
                    end
                    else
                    begin
                        entry_pos_reg[k] <= evt_reg.position;
                        entry_cnt_reg[k] <= CNT_W'(1);
                    end
                end
            end
        end
    end

    // Item capture, total and hottest search, products and share flags.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            evt_reg <= evt_data;
        end
        if (cmd.update)
        begin
            total_reg   <= TOT_W'(untracked_next);
            hot_cnt_reg <= '0;
            hot_pos_reg <= '0;
        end
        else if (cmd.scan_step && scan_valid)
        begin
            total_reg <= total_reg + TOT_W'(scan_cnt);
            if (scan_cnt > hot_cnt_reg)
            begin
                hot_cnt_reg <= scan_cnt;
                hot_pos_reg <= entry_pos_reg[ptr_reg];
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(total_reg) * PROD_W'(frac_reg[cmd.mul_sel]);
        end
        if (cmd.cmp_en)
        begin
            case (cmd.cmp_sel)
                hpap_pkg::CFG_OFFSET_COLD:
                begin
                    hot_cold_reg <= share_met(hot_cnt_reg, prod_reg);
                end
                hpap_pkg::CFG_OFFSET_EXIT:
                begin
                    hot_exit_reg <= share_met(hot_cnt_reg, prod_reg);
                end
                hpap_pkg::CFG_GENERAL_EXIT:
                begin
                    empty_exit_reg   <= share_met(empty_reg, prod_reg);
                    missing_exit_reg <= share_met(missing_reg, prod_reg);
                    nocow_exit_reg   <= share_met(nocow_reg, prod_reg);
                end
                hpap_pkg::CFG_MISSING_COLD:
                begin
                    empty_cold_reg   <= share_met(empty_reg, prod_reg);
                    missing_cold_reg <= share_met(missing_reg, prod_reg);
                end
                hpap_pkg::CFG_SMALL:
                begin
                    small_met_reg <= share_met(small_reg, prod_reg);
                end
                hpap_pkg::CFG_COW_COLD:
                begin
                    nocow_cold_reg <= share_met(nocow_reg, prod_reg);
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.emit)
        begin
            res_reg <= res_next;
        end
    end

    // Assemble the decision; no hot entry means no offset action.
    always_comb
    begin
        hot_act = (hot_cnt_reg != '0) ? hpap_pkg::pick_action(hot_exit_reg, hot_cold_reg)
                                      : hpap_pkg::ACT_NONE;
        res_next                 = '0;
        res_next.offset_action   = hot_act;
        res_next.offset_position = (hot_act == hpap_pkg::ACT_NONE) ? '0 : hot_pos_reg;
        res_next.small_hint      = small_met_reg;
        res_next.empty_action    = hpap_pkg::pick_action(empty_exit_reg, empty_cold_reg);
        res_next.missing_action  = hpap_pkg::pick_action(missing_exit_reg, missing_cold_reg);
        res_next.nocow_action    = hpap_pkg::pick_action(nocow_exit_reg, nocow_cold_reg);
    end

    assign res_data = res_reg;

endmodule
